[design/sdcf_pkg.sv]
// Shared widths, codes and item tag types for the sphere-to-cube-face pipeline.
// No dependencies; the top level refers to this package by scoped names.
`default_nettype none

package sdcf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  localparam int NINE_ONE  = 9 * ONE;
  localparam int THREE_ONE = 3 * ONE;
  localparam int TWELVE    = 12;

  // prescaled magnitudes: largest brought up to bit PS_TOP
  localparam int PS_W       = 32;
  localparam int PS_TOP     = 30;
  localparam int NORM_STEPS = 5;
  localparam int NORM_SH0   = 16;
  localparam int SUMSQ_W    = 2 * PS_W;
  localparam int LEN_W      = PS_W;

  localparam int NM_W    = FRAC_BITS + 1;
  localparam int NMNUM_W = PS_W + FRAC_BITS + 1;
  localparam int T_W     = FRAC_BITS + 2;
  localparam int D_W     = FRAC_BITS + 3;
  localparam int AD_W    = FRAC_BITS + 2;
  localparam int DD_W    = FRAC_BITS + 3;
  localparam int QS_W    = FRAC_BITS + 6;
  localparam int Q_W     = FRAC_BITS + 4;
  localparam int QARG_W  = Q_W + FRAC_BITS;
  localparam int R_W     = FRAC_BITS + 2;
  localparam int UM_W    = FRAC_BITS + 5;
  localparam int DEN_W   = FRAC_BITS + 3;
  localparam int SNUM_W  = UM_W + FRAC_BITS + 1;
  localparam int SM_W    = FRAC_BITS + 4;
  localparam int P_W     = FRAC_BITS + 6;
  localparam int H_W     = FRAC_BITS + 4;
  localparam int HARG_W  = H_W + FRAC_BITS;
  localparam int A_W     = FRAC_BITS + 2;
  localparam int LS_W    = A_W + 1;
  localparam int LOC_W   = FRAC_BITS + 2;
  localparam int FACE_W  = 3;

  typedef logic [1:0] dom_t;
  localparam dom_t DOM_X = 2'd0;
  localparam dom_t DOM_Y = 2'd1;
  localparam dom_t DOM_Z = 2'd2;

  typedef logic [FACE_W-1:0] face_t;
  localparam face_t FACE_POS_X = 3'd0;
  localparam face_t FACE_NEG_X = 3'd1;
  localparam face_t FACE_POS_Y = 3'd2;
  localparam face_t FACE_NEG_Y = 3'd3;
  localparam face_t FACE_POS_Z = 3'd4;
  localparam face_t FACE_NEG_Z = 3'd5;

  typedef struct packed {
    logic zero;
    dom_t dom;
    logic neg_d;
    logic neg_j;
    logic neg_k;
  } flag_t;

  typedef struct packed {
    flag_t             fl;
    logic [PS_W-1:0]   md;
    logic [PS_W-1:0]   mj;
    logic [PS_W-1:0]   mk;
  } pre_t;

  typedef struct packed {
    flag_t           fl;
    logic [PS_W-1:0] mj;
    logic [PS_W-1:0] mk;
  } ltag_t;

  typedef struct packed {
    flag_t                 fl;
    logic signed [D_W-1:0] d;
    logic                  num_neg;
    logic [UM_W-1:0]       um;
  } rtag_t;

  typedef struct packed {
    flag_t                 fl;
    logic signed [D_W-1:0] d;
    logic                  num_neg;
  } stag_t;

endpackage

`default_nettype wire

[design/sdcf_isqrt_pipe.sv]
// Pipelined integer square root, one result bit per register stage.
// Generic unit; a tag vector rides along with each item. No package use.
`default_nettype none

module sdcf_isqrt_pipe #(
  parameter int IN_W  = 64,
  parameter int OUT_W = 32,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [IN_W-1:0]  in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int EW = 2 * OUT_W + 1;

  logic             valid_r [OUT_W];
  logic [IN_W-1:0]  rem_r   [OUT_W];
  logic [OUT_W-1:0] root_r  [OUT_W];
  logic [TAG_W-1:0] tag_r   [OUT_W];

  genvar k;
  for (k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic             v_in;
    logic [IN_W-1:0]  rem_in;
    logic [OUT_W-1:0] root_in;
    logic [TAG_W-1:0] tag_in;
    logic [EW-1:0]    trial;
    logic [EW-1:0]    rem_ext;
    logic             take;
    logic [IN_W-1:0]  rem_nxt;
    logic [OUT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    always_comb begin
      trial    = (EW'(root_in) << (B + 1)) + (EW'(1) << (2 * B));
      rem_ext  = EW'(rem_in);
      take     = (rem_ext >= trial);
      rem_nxt  = take ? IN_W'(rem_ext - trial) : rem_in;
      root_nxt = take ? (root_in | (OUT_W'(1) << B)) : root_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= v_in;
      end
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      tag_r[k]  <= tag_in;
    end
  end

  assign out_valid = valid_r[OUT_W-1];
  assign out_root  = root_r[OUT_W-1];
  assign out_tag   = tag_r[OUT_W-1];

endmodule

`default_nettype wire

[design/sdcf_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Generic unit; needs num < den * 2^Q_W. No package use.
`default_nettype none

module sdcf_div_pipe #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32,
  parameter int Q_W   = 17,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quot,
  output logic [TAG_W-1:0] out_tag
);

  localparam int EW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             valid_r [Q_W];
  logic [NUM_W-1:0] rem_r   [Q_W];
  logic [DEN_W-1:0] den_r   [Q_W];
  logic [Q_W-1:0]   quot_r  [Q_W];
  logic [TAG_W-1:0] tag_r   [Q_W];

  genvar k;
  for (k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quot_in;
    logic [TAG_W-1:0] tag_in;
    logic [EW-1:0]    trial;
    logic [EW-1:0]    rem_ext;
    logic             take;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quot_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quot_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quot_in = quot_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    always_comb begin
      trial    = EW'(den_in) << B;
      rem_ext  = EW'(rem_in);
      take     = (rem_ext >= trial);
      rem_nxt  = take ? NUM_W'(rem_ext - trial) : rem_in;
      quot_nxt = take ? (quot_in | (Q_W'(1) << B)) : quot_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= v_in;
      end
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= den_in;
      quot_r[k] <= quot_nxt;
      tag_r[k]  <= tag_in;
    end
  end

  assign out_valid = valid_r[Q_W-1];
  assign out_quot  = quot_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

`default_nettype wire

[design/sphere_direction_to_cube_face.sv]
// Top level: direction vector to cube face and Q1.16 face-local coordinates.
// Uses sdcf_pkg, sdcf_isqrt_pipe and sdcf_div_pipe.
//
// Usage:
//   Input: drive in_dir_x/y/z and pulse start; an item is taken on any edge
//   with start high. busy is always low, so one item can enter every cycle.
//   Output: out_valid is high for exactly one cycle per item, with out_face,
//   out_local_x, out_local_y and out_invalid. Results leave in input order.
//   Throughput: one item per cycle. The pipeline depth is set by the
//   bit-serial stages: 32 for the vector length root, 17 for the normalize
//   divide, 18 for each of the two later root stages and 20 for the S
//   divide, plus 14 stages of prescale, squaring and placement.
//   A zero vector gives out_invalid = 1 and zero face and coordinates.
//   Reset (rst_n low at a clock edge) clears every valid bit in flight;
//   items in the pipe are dropped. The receiver cannot stall the block,
//   so no backpressure path exists.
`default_nettype none

module sphere_direction_to_cube_face #(
  parameter int IN_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [IN_WIDTH-1:0]         in_dir_x,
  input  logic signed [IN_WIDTH-1:0]         in_dir_y,
  input  logic signed [IN_WIDTH-1:0]         in_dir_z,
  output logic                               out_valid,
  output logic [sdcf_pkg::FACE_W-1:0]        out_face,
  output logic signed [sdcf_pkg::LOC_W-1:0]  out_local_x,
  output logic signed [sdcf_pkg::LOC_W-1:0]  out_local_y,
  output logic                               out_invalid
);

  localparam int F = sdcf_pkg::FRAC_BITS;

  assign busy = 1'b0;

  // ---------------- front: magnitudes and dominant axis ----------------
  logic [IN_WIDTH-1:0] mag_x, mag_y, mag_z;
  logic                neg_x, neg_y, neg_z;
  sdcf_pkg::pre_t      pre_nxt, pre_r;
  logic                pre_v_r;

  always_comb begin
    neg_x = in_dir_x[IN_WIDTH-1];
    neg_y = in_dir_y[IN_WIDTH-1];
    neg_z = in_dir_z[IN_WIDTH-1];
    mag_x = neg_x ? (~in_dir_x + IN_WIDTH'(1)) : in_dir_x;
    mag_y = neg_y ? (~in_dir_y + IN_WIDTH'(1)) : in_dir_y;
    mag_z = neg_z ? (~in_dir_z + IN_WIDTH'(1)) : in_dir_z;
    pre_nxt.fl.zero = (mag_x == '0) && (mag_y == '0) && (mag_z == '0);
    if (mag_x >= mag_y && mag_x >= mag_z) begin
      pre_nxt.fl.dom   = sdcf_pkg::DOM_X;
      pre_nxt.fl.neg_d = neg_x;
      pre_nxt.fl.neg_j = neg_y;
      pre_nxt.fl.neg_k = neg_z;
      pre_nxt.md = sdcf_pkg::PS_W'(mag_x);
      pre_nxt.mj = sdcf_pkg::PS_W'(mag_y);
      pre_nxt.mk = sdcf_pkg::PS_W'(mag_z);
    end else if (mag_y >= mag_z) begin
      pre_nxt.fl.dom   = sdcf_pkg::DOM_Y;
      pre_nxt.fl.neg_d = neg_y;
      pre_nxt.fl.neg_j = neg_x;
      pre_nxt.fl.neg_k = neg_z;
      pre_nxt.md = sdcf_pkg::PS_W'(mag_y);
      pre_nxt.mj = sdcf_pkg::PS_W'(mag_x);
      pre_nxt.mk = sdcf_pkg::PS_W'(mag_z);
    end else begin
      pre_nxt.fl.dom   = sdcf_pkg::DOM_Z;
      pre_nxt.fl.neg_d = neg_z;
      pre_nxt.fl.neg_j = neg_x;
      pre_nxt.fl.neg_k = neg_y;
      pre_nxt.md = sdcf_pkg::PS_W'(mag_z);
      pre_nxt.mj = sdcf_pkg::PS_W'(mag_x);
      pre_nxt.mk = sdcf_pkg::PS_W'(mag_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else begin
      pre_v_r <= start;
    end
    pre_r <= pre_nxt;
  end

  // ---------------- prescale: binary-weighted normalize steps ----------------
  sdcf_pkg::pre_t norm_r   [sdcf_pkg::NORM_STEPS];
  logic           norm_v_r [sdcf_pkg::NORM_STEPS];

  genvar n;
  for (n = 0; n < sdcf_pkg::NORM_STEPS; n++) begin : g_norm
    localparam int SH = sdcf_pkg::NORM_SH0 >> n;
    sdcf_pkg::pre_t p_in, p_nxt;
    logic           v_in;

    if (n == 0) begin : g_first
      assign p_in = pre_r;
      assign v_in = pre_v_r;
    end else begin : g_next
      assign p_in = norm_r[n-1];
      assign v_in = norm_v_r[n-1];
    end

    // shift all three together while the largest stays below 2^(PS_TOP+1)
    always_comb begin
      p_nxt = p_in;
      if ((p_in.md >> (sdcf_pkg::PS_TOP + 1 - SH)) == '0) begin
        p_nxt.md = p_in.md << SH;
        p_nxt.mj = p_in.mj << SH;
        p_nxt.mk = p_in.mk << SH;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        norm_v_r[n] <= 1'b0;
      end else begin
        norm_v_r[n] <= v_in;
      end
      norm_r[n] <= p_nxt;
    end
  end

  // ---------------- squares and sum ----------------
  sdcf_pkg::pre_t               sq_p_r;
  logic                         sq_v_r;
  logic [sdcf_pkg::SUMSQ_W-1:0] sqd_nxt, sqj_nxt, sqk_nxt;
  logic [sdcf_pkg::SUMSQ_W-1:0] sqd_r, sqj_r, sqk_r;
  logic [sdcf_pkg::SUMSQ_W-1:0] m2_nxt, m2_r;
  sdcf_pkg::ltag_t              lt_nxt, lt_r;
  logic                         m2_v_r;

  always_comb begin
    sqd_nxt = norm_r[sdcf_pkg::NORM_STEPS-1].md * norm_r[sdcf_pkg::NORM_STEPS-1].md;
    sqj_nxt = norm_r[sdcf_pkg::NORM_STEPS-1].mj * norm_r[sdcf_pkg::NORM_STEPS-1].mj;
    sqk_nxt = norm_r[sdcf_pkg::NORM_STEPS-1].mk * norm_r[sdcf_pkg::NORM_STEPS-1].mk;
  end

  always_comb begin
    m2_nxt    = sqd_r + sqj_r + sqk_r;
    lt_nxt.fl = sq_p_r.fl;
    lt_nxt.mj = sq_p_r.mj;
    lt_nxt.mk = sq_p_r.mk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else begin
      sq_v_r <= norm_v_r[sdcf_pkg::NORM_STEPS-1];
      m2_v_r <= sq_v_r;
    end
    sq_p_r <= norm_r[sdcf_pkg::NORM_STEPS-1];
    sqd_r  <= sqd_nxt;
    sqj_r  <= sqj_nxt;
    sqk_r  <= sqk_nxt;
    m2_r   <= m2_nxt;
    lt_r   <= lt_nxt;
  end

  // ---------------- vector length ----------------
  logic                       len_v;
  logic [sdcf_pkg::LEN_W-1:0] len;
  sdcf_pkg::ltag_t            len_tag;

  sdcf_isqrt_pipe #(
    .IN_W  (sdcf_pkg::SUMSQ_W),
    .OUT_W (sdcf_pkg::LEN_W),
    .TAG_W ($bits(sdcf_pkg::ltag_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m2_v_r),
    .in_val    (m2_r),
    .in_tag    (lt_r),
    .out_valid (len_v),
    .out_root  (len),
    .out_tag   (len_tag)
  );

  // ---------------- normalize: m * ONE / len, rounded ----------------
  logic [sdcf_pkg::NMNUM_W-1:0] numj, numk;
  logic                         nm_v, nmk_v, nmk_neg;
  logic [sdcf_pkg::NM_W-1:0]    nmj, nmk;
  sdcf_pkg::flag_t              nm_fl;

  always_comb begin
    numj = (sdcf_pkg::NMNUM_W'(len_tag.mj) << F) + sdcf_pkg::NMNUM_W'(len >> 1);
    numk = (sdcf_pkg::NMNUM_W'(len_tag.mk) << F) + sdcf_pkg::NMNUM_W'(len >> 1);
  end

  sdcf_div_pipe #(
    .NUM_W (sdcf_pkg::NMNUM_W),
    .DEN_W (sdcf_pkg::LEN_W),
    .Q_W   (sdcf_pkg::NM_W),
    .TAG_W ($bits(sdcf_pkg::flag_t))
  ) u_div_j (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (len_v),
    .in_num    (numj),
    .in_den    (len),
    .in_tag    (len_tag.fl),
    .out_valid (nm_v),
    .out_quot  (nmj),
    .out_tag   (nm_fl)
  );

  sdcf_div_pipe #(
    .NUM_W (sdcf_pkg::NMNUM_W),
    .DEN_W (sdcf_pkg::LEN_W),
    .Q_W   (sdcf_pkg::NM_W),
    .TAG_W (1)
  ) u_div_k (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (len_v),
    .in_num    (numk),
    .in_den    (len),
    .in_tag    (len_tag.fl.neg_k),
    .out_valid (nmk_v),
    .out_quot  (nmk),
    .out_tag   (nmk_neg)
  );

  // ---------------- Q1: rounded squares of the two side components ----------------
  localparam int PJ_W = 2 * sdcf_pkg::NM_W + 1;
  logic [PJ_W-1:0]           pj, pk;
  logic [sdcf_pkg::NM_W-1:0] j2_nxt, k2_nxt, j2_r, k2_r;
  sdcf_pkg::flag_t           fl1_nxt, fl1_r;
  logic                      q1_v_r;

  always_comb begin
    pj      = PJ_W'(nmj) * PJ_W'(nmj) + PJ_W'(sdcf_pkg::HALF);
    pk      = PJ_W'(nmk) * PJ_W'(nmk) + PJ_W'(sdcf_pkg::HALF);
    j2_nxt  = sdcf_pkg::NM_W'(pj >> F);
    k2_nxt  = sdcf_pkg::NM_W'(pk >> F);
    fl1_nxt = nm_fl;
    // a side component that normalized to zero carries no sign
    fl1_nxt.neg_j = nm_fl.neg_j && (nmj != '0);
    fl1_nxt.neg_k = nmk_neg && (nmk != '0);
  end

  // ---------------- Q2: T and D ----------------
  logic [sdcf_pkg::T_W-1:0]         t_nxt, t_r;
  logic signed [sdcf_pkg::D_W-1:0]  dj, dk, d_nxt, d_r;
  logic [sdcf_pkg::AD_W-1:0]        ad_nxt, ad_r;
  sdcf_pkg::flag_t                  fl2_r;
  logic                             q2_v_r;

  always_comb begin
    t_nxt  = sdcf_pkg::T_W'(j2_r) + sdcf_pkg::T_W'(k2_r);
    dj     = signed'(sdcf_pkg::D_W'(j2_r));
    dk     = signed'(sdcf_pkg::D_W'(k2_r));
    d_nxt  = (dj - dk) <<< 1;
    ad_nxt = d_nxt[sdcf_pkg::D_W-1] ? sdcf_pkg::AD_W'(-d_nxt) : sdcf_pkg::AD_W'(d_nxt);
  end

  // ---------------- Q3: D^2 ----------------
  localparam int PD_W = 2 * sdcf_pkg::AD_W + 1;
  logic [PD_W-1:0]                 pd;
  logic [sdcf_pkg::DD_W-1:0]       dd_nxt, dd_r;
  logic [sdcf_pkg::T_W-1:0]        t3_r;
  logic signed [sdcf_pkg::D_W-1:0] d3_r;
  sdcf_pkg::flag_t                 fl3_r;
  logic                            q3_v_r;

  always_comb begin
    pd     = PD_W'(ad_r) * PD_W'(ad_r) + PD_W'(sdcf_pkg::HALF);
    dd_nxt = sdcf_pkg::DD_W'(pd >> F);
  end

  // ---------------- Q4: Q clamped, numerator of S ----------------
  logic signed [sdcf_pkg::QS_W-1:0] ts, dds, qs, num;
  logic [sdcf_pkg::Q_W-1:0]         q_nxt, q_r;
  sdcf_pkg::rtag_t                  rt_nxt, rt_r;
  logic                             q4_v_r;

  always_comb begin
    ts  = signed'(sdcf_pkg::QS_W'(t3_r)) * signed'(sdcf_pkg::QS_W'(sdcf_pkg::TWELVE));
    dds = signed'(sdcf_pkg::QS_W'(dd_r));
    qs  = signed'(sdcf_pkg::QS_W'(sdcf_pkg::NINE_ONE)) - ts + dds;
    num = ts - dds;
    q_nxt = qs[sdcf_pkg::QS_W-1] ? '0 : sdcf_pkg::Q_W'(qs);
    rt_nxt.fl      = fl3_r;
    rt_nxt.d       = d3_r;
    rt_nxt.num_neg = num[sdcf_pkg::QS_W-1];
    rt_nxt.um      = num[sdcf_pkg::QS_W-1] ? sdcf_pkg::UM_W'(-num) : sdcf_pkg::UM_W'(num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
      q2_v_r <= 1'b0;
      q3_v_r <= 1'b0;
      q4_v_r <= 1'b0;
    end else begin
      q1_v_r <= nm_v && nmk_v;
      q2_v_r <= q1_v_r;
      q3_v_r <= q2_v_r;
      q4_v_r <= q3_v_r;
    end
    j2_r  <= j2_nxt;
    k2_r  <= k2_nxt;
    fl1_r <= fl1_nxt;
    t_r   <= t_nxt;
    d_r   <= d_nxt;
    ad_r  <= ad_nxt;
    fl2_r <= fl1_r;
    dd_r  <= dd_nxt;
    t3_r  <= t_r;
    d3_r  <= d_r;
    fl3_r <= fl2_r;
    q_r   <= q_nxt;
    rt_r  <= rt_nxt;
  end

  // ---------------- sqrt(Q) ----------------
  logic                     r_v;
  logic [sdcf_pkg::R_W-1:0] r_root;
  sdcf_pkg::rtag_t          r_tag;

  sdcf_isqrt_pipe #(
    .IN_W  (sdcf_pkg::QARG_W),
    .OUT_W (sdcf_pkg::R_W),
    .TAG_W ($bits(sdcf_pkg::rtag_t))
  ) u_q_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q4_v_r),
    .in_val    (sdcf_pkg::QARG_W'(q_r) << F),
    .in_tag    (rt_r),
    .out_valid (r_v),
    .out_root  (r_root),
    .out_tag   (r_tag)
  );

  // ---------------- S = num * ONE / (3 ONE + sqrt Q), rounded ----------------
  logic [sdcf_pkg::DEN_W-1:0]  sden;
  logic [sdcf_pkg::SNUM_W-1:0] snum;
  sdcf_pkg::stag_t             st_in;
  logic                        s_v;
  logic [sdcf_pkg::SM_W-1:0]   sm;
  sdcf_pkg::stag_t             s_tag;

  always_comb begin
    sden = sdcf_pkg::DEN_W'(sdcf_pkg::THREE_ONE) + sdcf_pkg::DEN_W'(r_root);
    snum = (sdcf_pkg::SNUM_W'(r_tag.um) << F) + sdcf_pkg::SNUM_W'(sden >> 1);
    st_in.fl      = r_tag.fl;
    st_in.d       = r_tag.d;
    st_in.num_neg = r_tag.num_neg;
  end

  sdcf_div_pipe #(
    .NUM_W (sdcf_pkg::SNUM_W),
    .DEN_W (sdcf_pkg::DEN_W),
    .Q_W   (sdcf_pkg::SM_W),
    .TAG_W ($bits(sdcf_pkg::stag_t))
  ) u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_v),
    .in_num    (snum),
    .in_den    (sden),
    .in_tag    (st_in),
    .out_valid (s_v),
    .out_quot  (sm),
    .out_tag   (s_tag)
  );

  // ---------------- (S +- D) / 2, clamped at zero ----------------
  logic signed [sdcf_pkg::P_W-1:0] sp, ss, dp, pa, pb;
  logic [sdcf_pkg::H_W-1:0]        ha_nxt, hb_nxt, ha_r, hb_r;
  sdcf_pkg::flag_t                 fl5_r;
  logic                            h_v_r;

  always_comb begin
    sp = signed'(sdcf_pkg::P_W'(sm));
    ss = s_tag.num_neg ? -sp : sp;
    dp = sdcf_pkg::P_W'(s_tag.d);
    pa = ss + dp;
    pb = ss - dp;
    ha_nxt = (!pa[sdcf_pkg::P_W-1] && pa != '0) ? sdcf_pkg::H_W'(pa >>> 1) : '0;
    hb_nxt = (!pb[sdcf_pkg::P_W-1] && pb != '0) ? sdcf_pkg::H_W'(pb >>> 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else begin
      h_v_r <= s_v;
    end
    ha_r  <= ha_nxt;
    hb_r  <= hb_nxt;
    fl5_r <= s_tag.fl;
  end

  // ---------------- the two local roots ----------------
  logic                     a_v, b_v, b_neg;
  logic [sdcf_pkg::A_W-1:0] ra, rb;
  sdcf_pkg::flag_t          a_fl;

  sdcf_isqrt_pipe #(
    .IN_W  (sdcf_pkg::HARG_W),
    .OUT_W (sdcf_pkg::A_W),
    .TAG_W ($bits(sdcf_pkg::flag_t))
  ) u_a_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h_v_r),
    .in_val    (sdcf_pkg::HARG_W'(ha_r) << F),
    .in_tag    (fl5_r),
    .out_valid (a_v),
    .out_root  (ra),
    .out_tag   (a_fl)
  );

  sdcf_isqrt_pipe #(
    .IN_W  (sdcf_pkg::HARG_W),
    .OUT_W (sdcf_pkg::A_W),
    .TAG_W (1)
  ) u_b_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h_v_r),
    .in_val    (sdcf_pkg::HARG_W'(hb_r) << F),
    .in_tag    (fl5_r.neg_k),
    .out_valid (b_v),
    .out_root  (rb),
    .out_tag   (b_neg)
  );

  // ---------------- face placement and saturation ----------------
  function automatic logic signed [sdcf_pkg::LOC_W-1:0] sat_loc(
    input logic signed [sdcf_pkg::LS_W-1:0] v
  );
    logic signed [sdcf_pkg::LS_W-1:0] one_v;
    one_v = signed'(sdcf_pkg::LS_W'(sdcf_pkg::ONE));
    if (v > one_v) begin
      sat_loc = sdcf_pkg::LOC_W'(one_v);
    end else if (v < -one_v) begin
      sat_loc = sdcf_pkg::LOC_W'(-one_v);
    end else begin
      sat_loc = sdcf_pkg::LOC_W'(v);
    end
  endfunction

  logic signed [sdcf_pkg::LS_W-1:0]  sa, sb, lx, ly;
  logic [sdcf_pkg::FACE_W-1:0]       face_nxt, face_r;
  logic signed [sdcf_pkg::LOC_W-1:0] lx_nxt, ly_nxt, lx_r, ly_r;
  logic                              inv_r, out_v_r;

  always_comb begin
    sa = signed'(sdcf_pkg::LS_W'(ra));
    sb = signed'(sdcf_pkg::LS_W'(rb));
    if (a_fl.neg_j) sa = -sa;
    if (b_neg) sb = -sb;
    face_nxt = sdcf_pkg::FACE_POS_X;
    lx = sa;
    ly = sb;
    case (a_fl.dom)
      sdcf_pkg::DOM_X: begin
        ly = sa;
        if (!a_fl.neg_d) begin
          face_nxt = sdcf_pkg::FACE_POS_X;
          lx = -sb;
        end else begin
          face_nxt = sdcf_pkg::FACE_NEG_X;
          lx = sb;
        end
      end
      sdcf_pkg::DOM_Y: begin
        lx = sa;
        if (!a_fl.neg_d) begin
          face_nxt = sdcf_pkg::FACE_POS_Y;
          ly = -sb;
        end else begin
          face_nxt = sdcf_pkg::FACE_NEG_Y;
          ly = sb;
        end
      end
      default: begin
        ly = sb;
        if (!a_fl.neg_d) begin
          face_nxt = sdcf_pkg::FACE_POS_Z;
          lx = sa;
        end else begin
          face_nxt = sdcf_pkg::FACE_NEG_Z;
          lx = -sa;
        end
      end
    endcase
    lx_nxt = sat_loc(lx);
    ly_nxt = sat_loc(ly);
    if (a_fl.zero) begin
      face_nxt = sdcf_pkg::FACE_POS_X;
      lx_nxt   = '0;
      ly_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= a_v && b_v;
    end
    face_r <= face_nxt;
    lx_r   <= lx_nxt;
    ly_r   <= ly_nxt;
    inv_r  <= a_fl.zero;
  end

  assign out_valid   = out_v_r;
  assign out_face    = face_r;
  assign out_local_x = lx_r;
  assign out_local_y = ly_r;
  assign out_invalid = inv_r;

endmodule

`default_nettype wire
